// ----- hdl/tpe_pkg.sv -----
// ----------------------------------------------------------------------------
// tpe_pkg
// Shared types and constants of the triangle plane equation unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpe_pkg;

	localparam int VERTEX_COUNT_DEF = 256;
	localparam int QUEUE_DEPTH      = 4;
	localparam int DIV_STEPS        = 31;
	localparam int SQRT_STEPS       = 34;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [1:0] REG_EDGE_EPSILON = 2'd0;
	localparam logic [1:0] REG_UNIT_SCALE   = 2'd1;
	localparam logic [1:0] REG_OFFSET_BIAS  = 2'd2;

	localparam logic [31:0]        EPS_RESET   = 32'd0;
	localparam logic [17:0]        SCALE_RESET = 18'd65536;
	localparam logic signed [31:0] BIAS_RESET  = 32'sd0;

	typedef struct packed {
		logic               operation;
		logic [7:0]         vertex_slot;
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic [7:0]         corner_a;
		logic [7:0]         corner_b;
		logic [7:0]         corner_c;
	} tpe_req_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic signed [31:0] plane_distance;
		logic               degenerate;
	} tpe_rsp_t;

	typedef struct packed {
		logic [31:0]        edge_epsilon;
		logic [17:0]        unit_scale;
		logic signed [31:0] offset_bias;
	} tpe_cfg_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} tpe_vec_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [33:0] den;
	} tpe_div_req_t;

	typedef struct packed {
		logic        done;
		logic [30:0] quo;
	} tpe_div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [65:0] radicand;
	} tpe_sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [33:0] root;
	} tpe_sqrt_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/tpe_front.sv -----
// ----------------------------------------------------------------------------
// tpe_front
// Request stage: takes requests, drops writes beyond the store, range-checks
// corners and packs each request into a queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_front
	import tpe_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int AW = $clog2(VERTEX_COUNT),
	parameter int QW = 100 + 4 * AW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire tpe_req_t      req,
	input  wire logic          full,
	output logic               push,
	output logic [QW-1:0]      push_data
);

	logic          stage_valid_q;
	logic [QW-1:0] stage_q;
	logic          accept;
	logic          keep;
	logic [31:0]   slot_ext, a_ext, b_ext, c_ext;
	logic          slot_ok, a_ok, b_ok, c_ok;

	always_comb begin
		slot_ext = 32'(req.vertex_slot);
		a_ext    = 32'(req.corner_a);
		b_ext    = 32'(req.corner_b);
		c_ext    = 32'(req.corner_c);
		slot_ok  = slot_ext < 32'(VERTEX_COUNT);
		a_ok     = a_ext < 32'(VERTEX_COUNT);
		b_ok     = b_ext < 32'(VERTEX_COUNT);
		c_ok     = c_ext < 32'(VERTEX_COUNT);
		// writes beyond the store vanish here
		keep     = (req.operation == OP_COMPUTE) || slot_ok;
	end

	assign push      = stage_valid_q && !full;
	assign req_ready = !stage_valid_q || !full;
	assign accept    = req_valid && req_ready;
	assign push_data = stage_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= 1'b0;
		end else if (accept && keep) begin
			stage_valid_q <= 1'b1;
		end else if (push) begin
			stage_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && keep) begin
			stage_q <= {req.operation, slot_ext[AW-1:0],
				req.coord_x, req.coord_y, req.coord_z,
				a_ok, a_ext[AW-1:0], b_ok, b_ext[AW-1:0], c_ok, c_ext[AW-1:0]};
		end
	end

endmodule

`default_nettype wire

// ----- hdl/tpe_queue.sv -----
// ----------------------------------------------------------------------------
// tpe_queue
// Small first-in first-out queue between the request stage and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_queue
	import tpe_pkg::*;
#(
	parameter int WIDTH = 132,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      head,
	output logic                  empty,
	output logic                  full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [PW:0]      cnt_q;

	function automatic logic [PW-1:0] step(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW + 1)'(DEPTH));
	assign head  = slots_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= step(wr_q);
			end
			if (pop) begin
				rd_q <= step(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW + 1)'(DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/tpe_sqrt.sv -----
// ----------------------------------------------------------------------------
// tpe_sqrt
// Floor square root of a 66-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_sqrt
	import tpe_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tpe_sqrt_req_t sreq,
	output tpe_sqrt_rsp_t      srsp
);

	logic        busy_q, done_q;
	logic [5:0]  cnt_q;
	logic [67:0] x_q;
	logic [35:0] rem_q;
	logic [33:0] root_q;
	logic [37:0] t, trial;
	logic        ge;

	always_comb begin
		t     = {rem_q, x_q[67:66]};
		trial = {2'b00, root_q, 2'b01};
		ge    = t >= trial;
	end

	assign srsp.done = done_q;
	assign srsp.root = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (sreq.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 6'(SQRT_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sreq.start) begin
			x_q    <= {2'b00, sreq.radicand};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[65:0], 2'b00};
			rem_q  <= ge ? 36'(t - trial) : t[35:0];
			root_q <= {root_q[32:0], ge};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		sreq.start |-> !busy_q)
		else $error("root started while busy");

endmodule

`default_nettype wire

// ----- hdl/tpe_div.sv -----
// ----------------------------------------------------------------------------
// tpe_div
// Restoring divider, 64 by 34 bits, quotient saturated to 31 bits,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_div
	import tpe_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire tpe_div_req_t dreq,
	output tpe_div_rsp_t      drsp
);

	logic        busy_q, done_q;
	logic [4:0]  cnt_q;
	logic [33:0] den_q, rem_q;
	logic [30:0] low_q, quo_q;
	logic [34:0] t;
	logic        ge, sat, den_zero;

	always_comb begin
		t        = {rem_q, low_q[30]};
		ge       = t >= {1'b0, den_q};
		den_zero = (dreq.den == '0);
		sat      = {1'b0, dreq.num} >= {dreq.den, 31'd0};
	end

	assign drsp.done = done_q;
	assign drsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (dreq.start) begin
			busy_q <= !(den_zero || sat);
			done_q <= den_zero || sat;
			cnt_q  <= 5'(DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dreq.start) begin
			den_q <= dreq.den;
			rem_q <= {1'b0, dreq.num[63:31]};
			low_q <= dreq.num[30:0];
			quo_q <= (!den_zero && sat) ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= ge ? 34'(t - {1'b0, den_q}) : t[33:0];
			low_q <= {low_q[29:0], 1'b0};
			quo_q <= {quo_q[29:0], ge};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> !busy_q)
		else $error("divide started while busy");

endmodule

`default_nettype wire

// ----- hdl/tpe_back.sv -----
// ----------------------------------------------------------------------------
// tpe_back
// Engine: owns the vertex store, runs the edge, cross product, normal and
// distance sequence on one shared multiplier, root unit and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tpe_back
	import tpe_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF,
	parameter int AW = $clog2(VERTEX_COUNT),
	parameter int QW = 100 + 4 * AW
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire tpe_cfg_t      cfg,
	input  wire logic          q_empty,
	input  wire logic [QW-1:0] q_head,
	output logic               q_pop,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output tpe_rsp_t           rsp
);

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_RDB     = 5'd1;
	localparam logic [4:0] S_RDC     = 5'd2;
	localparam logic [4:0] S_RDX     = 5'd3;
	localparam logic [4:0] S_SQ_MUL  = 5'd4;
	localparam logic [4:0] S_SQ_ACC  = 5'd5;
	localparam logic [4:0] S_SQ_CHK  = 5'd6;
	localparam logic [4:0] S_SQRT    = 5'd7;
	localparam logic [4:0] S_SC_MUL  = 5'd8;
	localparam logic [4:0] S_SC_DIV  = 5'd9;
	localparam logic [4:0] S_SC_WAIT = 5'd10;
	localparam logic [4:0] S_CR_M1   = 5'd11;
	localparam logic [4:0] S_CR_M2   = 5'd12;
	localparam logic [4:0] S_CR_SUB  = 5'd13;
	localparam logic [4:0] S_DOT_MUL = 5'd14;
	localparam logic [4:0] S_DOT_ACC = 5'd15;
	localparam logic [4:0] S_FIN     = 5'd16;

	localparam logic [1:0] PH_E = 2'd0;
	localparam logic [1:0] PH_F = 2'd1;
	localparam logic [1:0] PH_N = 2'd2;

	// queue entry fields
	logic          h_op;
	logic [AW-1:0] h_slot;
	tpe_vec_t      h_vec;
	logic          h_a_ok, h_b_ok, h_c_ok;
	logic [AW-1:0] h_a_addr, h_b_addr, h_c_addr;

	assign {h_op, h_slot, h_vec, h_a_ok, h_a_addr, h_b_ok, h_b_addr,
		h_c_ok, h_c_addr} = q_head;

	logic [95:0]   mem [VERTEX_COUNT];
	tpe_vec_t      rd_q;
	logic [AW-1:0] rd_addr;
	logic          mem_we;

	logic [4:0]  state_q;
	logic [1:0]  phase_q, k_q;
	logic        a_ok_q, b_ok_q, c_ok_q;
	logic [AW-1:0] b_addr_q, c_addr_q;
	logic        degen_q;
	logic        rsp_valid_q;
	tpe_rsp_t    rsp_q;

	logic signed [31:0] pa_q [3];
	logic signed [31:0] pb_q [3];
	logic signed [32:0] e_q [3];
	logic signed [32:0] f_q [3];
	logic signed [31:0] ue_q [3];
	logic signed [31:0] uf_q [3];
	logic signed [27:0] n_q [3];
	logic signed [31:0] nrm_q [3];

	logic [65:0]        acc_q;
	logic signed [65:0] prod_q, t_q;
	logic [33:0]        root_q;

	logic signed [32:0] mul_a, mul_b, vk, vabs;
	logic signed [65:0] prod_full, diff, dabs;
	logic [29:0]        dmag;
	logic [1:0]         ia, ib;
	logic               vneg, pass;
	logic signed [31:0] pc [3];
	logic signed [31:0] qv;
	logic signed [35:0] dot;
	logic signed [37:0] d_wide;
	logic signed [31:0] d_sat;
	logic               load;

	tpe_div_req_t  dreq;
	tpe_div_rsp_t  drsp;
	tpe_sqrt_req_t sreq;
	tpe_sqrt_rsp_t srsp;

	function automatic logic [1:0] nxt(input logic [1:0] i);
		logic [1:0] r;
		unique case (i)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	tpe_sqrt u_sqrt (.clk(clk), .arst_n(arst_n), .sreq(sreq), .srsp(srsp));
	tpe_div  u_div  (.clk(clk), .arst_n(arst_n), .dreq(dreq), .drsp(drsp));

	// vertex store
	assign mem_we = (state_q == S_IDLE) && !q_empty && (h_op == OP_WRITE);

	always_comb begin
		unique case (state_q)
			S_RDB:   rd_addr = b_addr_q;
			S_RDC:   rd_addr = c_addr_q;
			default: rd_addr = h_a_addr;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[h_slot] <= h_vec;
		end
		rd_q <= mem[rd_addr];
	end

	// operand selection
	always_comb begin
		unique case (phase_q)
			PH_E:    vk = e_q[k_q];
			PH_F:    vk = f_q[k_q];
			default: vk = 33'(n_q[k_q]);
		endcase
		vneg = vk[32];
		vabs = vneg ? -vk : vk;
		ia   = (state_q == S_CR_M1) ? nxt(k_q) : nxt(nxt(k_q));
		ib   = (state_q == S_CR_M1) ? nxt(nxt(k_q)) : nxt(k_q);

		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = vk;
				mul_b = vk;
			end
			S_SC_MUL: begin
				mul_a = vabs;
				mul_b = {15'd0, cfg.unit_scale};
			end
			S_CR_M1, S_CR_M2: begin
				mul_a = 33'(ue_q[ia]);
				mul_b = 33'(uf_q[ib]);
			end
			S_DOT_MUL: begin
				mul_a = 33'(pb_q[k_q]);
				mul_b = 33'(nrm_q[k_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_full = mul_a * mul_b;

		pc[0] = c_ok_q ? rd_q.x : 32'sd0;
		pc[1] = c_ok_q ? rd_q.y : 32'sd0;
		pc[2] = c_ok_q ? rd_q.z : 32'sd0;

		// truncate toward zero by 2^36
		diff = t_q - prod_q;
		dabs = diff[65] ? -diff : diff;
		dmag = dabs[65:36];

		if (phase_q == PH_N) begin
			pass = acc_q > {2'd0, cfg.edge_epsilon, 32'd0};
		end else begin
			pass = acc_q > {18'd0, cfg.edge_epsilon, 16'd0};
		end

		qv = vneg ? -$signed({1'b0, drsp.quo}) : $signed({1'b0, drsp.quo});

		dot    = $signed(acc_q[65:30]);
		d_wide = 38'(cfg.offset_bias) - 38'(dot);
		if (d_wide > 38'sd2147483647) begin
			d_sat = 32'sh7fffffff;
		end else if (d_wide < -38'sd2147483648) begin
			d_sat = 32'sh80000000;
		end else begin
			d_sat = d_wide[31:0];
		end

		sreq.start    = (state_q == S_SQ_CHK) && pass;
		sreq.radicand = acc_q;
		dreq.start    = (state_q == S_SC_DIV);
		dreq.num      = {prod_q[49:0], 14'd0};
		dreq.den      = root_q;
	end

	assign q_pop     = (state_q == S_IDLE) && !q_empty;
	assign load      = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_E;
			k_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!q_empty && h_op == OP_COMPUTE) begin
						state_q <= S_RDB;
					end
				end
				S_RDB: state_q <= S_RDC;
				S_RDC: state_q <= S_RDX;
				S_RDX: begin
					state_q <= S_SQ_MUL;
					phase_q <= PH_E;
					k_q     <= '0;
				end
				S_SQ_MUL: state_q <= S_SQ_ACC;
				S_SQ_ACC: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_SQ_CHK;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_SQ_MUL;
					end
				end
				S_SQ_CHK: begin
					k_q     <= '0;
					state_q <= pass ? S_SQRT : S_DOT_MUL;
				end
				S_SQRT: begin
					if (srsp.done) begin
						state_q <= S_SC_MUL;
					end
				end
				S_SC_MUL: state_q <= S_SC_DIV;
				S_SC_DIV: state_q <= S_SC_WAIT;
				S_SC_WAIT: begin
					if (drsp.done) begin
						if (k_q != 2'd2) begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SC_MUL;
						end else begin
							k_q <= '0;
							unique case (phase_q)
								PH_E: begin
									phase_q <= PH_F;
									state_q <= S_SQ_MUL;
								end
								PH_F:    state_q <= S_CR_M1;
								default: state_q <= S_DOT_MUL;
							endcase
						end
					end
				end
				S_CR_M1: state_q <= S_CR_M2;
				S_CR_M2: state_q <= S_CR_SUB;
				S_CR_SUB: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						phase_q <= PH_N;
						state_q <= S_SQ_MUL;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_CR_M1;
					end
				end
				S_DOT_MUL: state_q <= S_DOT_ACC;
				S_DOT_ACC: begin
					if (k_q == 2'd2) begin
						state_q <= S_FIN;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_DOT_MUL;
					end
				end
				S_FIN: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= prod_full;
		unique case (state_q)
			S_IDLE: begin
				a_ok_q   <= h_a_ok;
				b_ok_q   <= h_b_ok;
				c_ok_q   <= h_c_ok;
				b_addr_q <= h_b_addr;
				c_addr_q <= h_c_addr;
			end
			S_RDB: begin
				pa_q[0] <= a_ok_q ? rd_q.x : 32'sd0;
				pa_q[1] <= a_ok_q ? rd_q.y : 32'sd0;
				pa_q[2] <= a_ok_q ? rd_q.z : 32'sd0;
			end
			S_RDC: begin
				pb_q[0] <= b_ok_q ? rd_q.x : 32'sd0;
				pb_q[1] <= b_ok_q ? rd_q.y : 32'sd0;
				pb_q[2] <= b_ok_q ? rd_q.z : 32'sd0;
			end
			S_RDX: begin
				for (int i = 0; i < 3; i++) begin
					e_q[i]   <= 33'(pc[i]) - 33'(pa_q[i]);
					f_q[i]   <= 33'(pa_q[i]) - 33'(pb_q[i]);
					nrm_q[i] <= 32'sd0;
				end
				acc_q   <= '0;
				degen_q <= 1'b1;
			end
			S_SQ_ACC: acc_q <= acc_q + {2'd0, prod_q[63:0]};
			S_SQ_CHK: acc_q <= '0;
			S_SQRT: begin
				if (srsp.done) begin
					root_q <= srsp.root;
				end
			end
			S_SC_WAIT: begin
				if (drsp.done) begin
					unique case (phase_q)
						PH_E:    ue_q[k_q] <= qv;
						PH_F:    uf_q[k_q] <= qv;
						default: nrm_q[k_q] <= qv;
					endcase
					if (k_q == 2'd2) begin
						acc_q <= '0;
						if (phase_q == PH_N) begin
							degen_q <= 1'b0;
						end
					end
				end
			end
			S_CR_M2: t_q <= prod_q;
			S_CR_SUB: begin
				n_q[k_q] <= diff[65] ? -$signed({1'b0, dmag[26:0]})
					: $signed({1'b0, dmag[26:0]});
				acc_q <= '0;
			end
			S_DOT_ACC: acc_q <= acc_q + prod_q;
			default: ;
		endcase
		if (load) begin
			rsp_q.normal_x       <= nrm_q[0];
			rsp_q.normal_y       <= nrm_q[1];
			rsp_q.normal_z       <= nrm_q[2];
			rsp_q.plane_distance <= d_sat;
			rsp_q.degenerate     <= degen_q;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.degenerate |->
		(rsp_q.normal_x == 0) && (rsp_q.normal_y == 0) && (rsp_q.normal_z == 0))
		else $error("degenerate result with nonzero normal");

endmodule

`default_nettype wire

// ----- hdl/triangle_plane_equation.sv -----
// ----------------------------------------------------------------------------
// triangle_plane_equation
// Vertex store plus plane equation engine: a request stage feeds a short
// queue, the engine behind it computes normal and distance per triangle.
//
//   channel   dir   handshake              payload
//   req       in    req_valid/req_ready    tpe_req_t
//   rsp       out   rsp_valid/rsp_ready    tpe_rsp_t
//   cfg       in    cfg_we                 cfg_index, cfg_data
//
// a vertex write is stored from the engine's idle state; a plane request runs
// the root unit once for each edge and the normal and the divider nine times;
// short edges end sooner.
// a result waiting on rsp_ready holds the engine in its last cycle.
// reset clears control and loads the configuration defaults; the vertex store is undefined until written.
// the queue lets requests be taken while the engine or the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_equation
	import tpe_pkg::*;
#(
	parameter int VERTEX_COUNT = VERTEX_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire tpe_req_t    req,
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output tpe_rsp_t         rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int QW = 100 + 4 * AW;

	tpe_cfg_t      cfg_q;
	logic          push, pop, full, empty;
	logic [QW-1:0] push_data, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.edge_epsilon <= EPS_RESET;
			cfg_q.unit_scale   <= SCALE_RESET;
			cfg_q.offset_bias  <= BIAS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EDGE_EPSILON: cfg_q.edge_epsilon <= cfg_data;
				REG_UNIT_SCALE:   cfg_q.unit_scale   <= cfg_data[17:0];
				REG_OFFSET_BIAS:  cfg_q.offset_bias  <= cfg_data;
				default: ;
			endcase
		end
	end

	tpe_front #(.VERTEX_COUNT(VERTEX_COUNT), .AW(AW), .QW(QW)) u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.full(full), .push(push), .push_data(push_data)
	);

	tpe_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .pop(pop),
		.head(head), .empty(empty), .full(full)
	);

	tpe_back #(.VERTEX_COUNT(VERTEX_COUNT), .AW(AW), .QW(QW)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_empty(empty), .q_head(head), .q_pop(pop),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

endmodule

`default_nettype wire
